### design/wps_pkg.sv
// Shared types, constants and rounding helpers for the wave pose block.
package wps_pkg;

    typedef struct packed {
        logic        [47:0] sim_time;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [15:0] heading;
        logic               paused;
    } wps_in_t;

    typedef struct packed {
        logic signed [31:0] height;
        logic signed [15:0] quat_w;
        logic signed [15:0] quat_x;
        logic signed [15:0] quat_y;
        logic signed [15:0] quat_z;
    } wps_out_t;

    typedef enum logic [2:0] {
        REG_MEAN_HEIGHT,
        REG_HEAVE_AMP,
        REG_ROLL_AMP,
        REG_PITCH_AMP,
        REG_FREQ_ONE,
        REG_FREQ_TWO,
        REG_WAVENUM_X,
        REG_WAVENUM_Y
    } wps_reg_t;

    typedef struct packed {
        logic        [1:0]  quad;
        logic        [30:0] r;
        logic        [30:0] z;
        logic signed [31:0] p;
    } wps_lane_t;

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;

    localparam int WPS_FIFO_DEPTH = 32;
    localparam int HORNER_STEPS   = 5;
    localparam int SINE_LAT       = HORNER_STEPS + 4;

    localparam logic signed [63:0] INV_2PI     = 64'sd683565276;
    localparam logic signed [63:0] INV_2PI_035 = 64'sd239247846;
    localparam logic signed [63:0] INV_2PI_055 = 64'sd375960902;
    localparam logic signed [63:0] INV_4PI     = 64'sd341782638;

    localparam logic [31:0] OFF_1P2      = 32'd820278331;
    localparam logic [31:0] OFF_0P8      = 32'd546852220;
    localparam logic [31:0] OFF_0P4      = 32'd273426110;
    localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;

    localparam logic signed [31:0] ONE_Q30 = 32'sd1073741824;
    localparam logic signed [31:0] WT_070  = 32'sd751619277;
    localparam logic signed [31:0] WT_030  = 32'sd322122547;
    localparam logic signed [31:0] WT_065  = 32'sd697932186;
    localparam logic signed [31:0] WT_035  = 32'sd375809638;

    localparam logic signed [31:0] PA1  = 32'sd1686629713;
    localparam logic signed [31:0] PA3  = -32'sd693598668;
    localparam logic signed [31:0] PA5  = 32'sd85569306;
    localparam logic signed [31:0] PA7  = -32'sd5026995;
    localparam logic signed [31:0] PA9  = 32'sd172272;
    localparam logic signed [31:0] PA11 = -32'sd3864;

    localparam logic signed [31:0] HORNER_COEF [HORNER_STEPS] = '{PA9, PA7, PA5, PA3, PA1};

    // Arithmetic right shift that rounds half away from zero.
    function automatic logic signed [63:0] round_shift(input logic signed [63:0] v,
                                                       input int unsigned n);
        logic signed [63:0] h;
        logic signed [63:0] neg;
        h   = 64'sd1 <<< (n - 1);
        neg = v[63] ? 64'sd1 : 64'sd0;
        return (v + h - neg) >>> n;
    endfunction

    function automatic logic signed [31:0] mul30(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
        logic signed [63:0] prod;
        prod = 64'(a) * 64'(b);
        return 32'(round_shift(prod, 30));
    endfunction

endpackage

### design/wps_horner_cell.sv
// One Horner step of the sine polynomial: p becomes coef plus z times p.
module wps_horner_cell
    import wps_pkg::*;
(
    input  logic               aclk,
    input  logic signed [31:0] coef,
    input  wps_lane_t          lane_in,
    output wps_lane_t          lane_out
);

    wps_lane_t lane_reg;

    always_ff @(posedge aclk) begin
        lane_reg.quad <= lane_in.quad;
        lane_reg.r    <= lane_in.r;
        lane_reg.z    <= lane_in.z;
        lane_reg.p    <= coef + mul30($signed({1'b0, lane_in.z}), lane_in.p);
    end

    assign lane_out = lane_reg;

endmodule

### design/wps_sine.sv
// Pipelined sine of a binary turn angle, Q2.30 result, built from Horner cells.
module wps_sine
    import wps_pkg::*;
(
    input  logic               aclk,
    input  logic        [31:0] u,
    output logic signed [31:0] s
);

    logic        [1:0]  quad_reg;
    logic        [30:0] r_reg;
    wps_lane_t          lane0_reg;
    wps_lane_t          lane [HORNER_STEPS + 1];
    logic        [1:0]  quad_fin_reg;
    logic signed [31:0] prod_reg;
    logic signed [31:0] s_reg;
    logic        [30:0] r_fold;
    logic signed [31:0] clamp;

    always_comb begin
        if (u[30]) begin
            r_fold = 31'(ONE_Q30) - {1'b0, u[29:0]};
        end else begin
            r_fold = {1'b0, u[29:0]};
        end
    end

    always_ff @(posedge aclk) begin
        quad_reg       <= u[31:30];
        r_reg          <= r_fold;
        lane0_reg.quad <= quad_reg;
        lane0_reg.r    <= r_reg;
        lane0_reg.z    <= 31'(mul30($signed({1'b0, r_reg}), $signed({1'b0, r_reg})));
        lane0_reg.p    <= PA11;
    end

    assign lane[0] = lane0_reg;

    for (genvar i = 0; i < HORNER_STEPS; i++) begin : g_cell
        wps_horner_cell u_cell (
            .aclk     (aclk),
            .coef     (HORNER_COEF[i]),
            .lane_in  (lane[i]),
            .lane_out (lane[i + 1])
        );
    end

    always_comb begin
        if (prod_reg < 0) begin
            clamp = 32'sd0;
        end else if (prod_reg > ONE_Q30) begin
            clamp = ONE_Q30;
        end else begin
            clamp = prod_reg;
        end
    end

    always_ff @(posedge aclk) begin
        quad_fin_reg <= lane[HORNER_STEPS].quad;
        prod_reg     <= mul30($signed({1'b0, lane[HORNER_STEPS].r}), lane[HORNER_STEPS].p);
        s_reg        <= quad_fin_reg[1] ? -clamp : clamp;
    end

    assign s = s_reg;

endmodule

### design/wave_pose_sum_of_sines.sv
// Top level of the wave pose block: phase, sine, mix and quaternion pipeline.
//
// Input words arrive on s_valid/s_ready/s_data and carry the time, the vessel
// position and its heading. Each word that is not paused yields one output
// word on m_valid/m_ready/m_data with the height and the orientation
// quaternion; a paused word is taken and dropped.
// The datapath is a free-running pipeline of 29 stages: phase products, two
// rows of sine evaluators built from Horner cells, the wave mixes and the
// quaternion products. A result passes through an output queue into the output
// register on m_data, and a new word is taken in every cycle in which s_ready is high.
// The block counts words in flight plus words queued, including the output
// register, and drops s_ready when that count reaches FIFO_DEPTH, so a stalled
// receiver never loses data and the block keeps accepting until the queue
// would fill.
// Configuration writes on cfg_we/cfg_addr/cfg_wdata take effect at the write edge;
// s_ready stays low for one cycle after a write while the phase coefficients follow;
// the user makes writes only while no word is in flight, which the block does not
// enforce. Reset returns the configuration registers to their defaults and empties
// the pipeline and the output queue; s_ready stays low in the first cycle after reset.
module wave_pose_sum_of_sines
    import wps_pkg::*;
#(
    parameter int FIFO_DEPTH = WPS_FIFO_DEPTH
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  wps_in_t               s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output wps_out_t              m_data,
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    localparam int PIPE_LAT = 3 + SINE_LAT + 4 + SINE_LAT + 4;
    localparam int HY_DLY   = 3 + SINE_LAT + 4;
    localparam int HGT_DLY  = SINE_LAT + 3;
    localparam int IDX_W    = $clog2(FIFO_DEPTH);
    localparam int CNT_W    = IDX_W + 1;

    function automatic logic signed [15:0] to_q15(input logic signed [32:0] v);
        logic signed [63:0] r;
        r = round_shift(64'(v), 15);
        if (r > 64'sd32767) begin
            return 16'sh7FFF;
        end else if (r < -64'sd32768) begin
            return 16'sh8000;
        end
        return 16'(r);
    endfunction

    logic signed [31:0] mean_height_reg;
    logic        [21:0] heave_amp_reg;
    logic        [17:0] roll_amp_reg;
    logic        [17:0] pitch_amp_reg;
    logic        [23:0] freq_one_reg;
    logic        [23:0] freq_two_reg;
    logic signed [23:0] wavenum_x_reg;
    logic signed [23:0] wavenum_y_reg;

    logic [63:0] coef_reg  [6];
    logic [63:0] opnd      [6];
    logic [63:0] lo_reg    [6];
    logic [31:0] cross_reg [6];
    logic [63:0] term_reg  [6];
    logic [31:0] ua_reg;
    logic [31:0] ub_reg;
    logic [31:0] hy_dly_reg [HY_DLY];

    logic signed [31:0] sin_a [5];
    logic signed [31:0] mix_reg [6];
    logic signed [32:0] mh_reg;
    logic signed [32:0] mr_reg;
    logic signed [32:0] mp_reg;
    logic signed [31:0] heave_reg;
    logic signed [35:0] rad_r_reg;
    logic signed [35:0] rad_p_reg;
    logic signed [32:0] hgt_sum;
    logic signed [31:0] hgt_reg;
    logic signed [31:0] hgt_dly_reg [HGT_DLY];
    logic        [31:0] hr_reg;
    logic        [31:0] hp_reg;
    logic signed [63:0] hr_prod;
    logic signed [63:0] hp_prod;

    logic signed [31:0] sr, cr, sp, cp, sy, cy;
    logic signed [31:0] cc_reg, ss_reg, sc_reg, cs_reg, cy_reg, sy_reg;
    logic signed [31:0] tw1_reg, tw2_reg, tx1_reg, tx2_reg;
    logic signed [31:0] ty1_reg, ty2_reg, tz1_reg, tz2_reg;
    logic signed [32:0] w_reg, qx_reg, qy_reg, qz_reg;
    wps_out_t           out_reg;

    logic [PIPE_LAT-1:0] vld_reg;
    wps_out_t            fifo_mem [FIFO_DEPTH];
    logic [CNT_W-1:0]    wr_ptr_reg;
    logic [CNT_W-1:0]    rd_ptr_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic [CNT_W-1:0]    cnt_next;
    logic                cfg_hold_reg;
    logic                m_valid_reg;
    wps_out_t            m_data_reg;
    logic                q_pop;
    logic                in_take;
    logic                out_take;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mean_height_reg <= 32'sd27525;
            heave_amp_reg   <= 22'd6554;
            roll_amp_reg    <= 18'd3604;
            pitch_amp_reg   <= 18'd2949;
            freq_one_reg    <= 24'd72090;
            freq_two_reg    <= 24'd111411;
            wavenum_x_reg   <= 24'sd22938;
            wavenum_y_reg   <= 24'sd14418;
        end else if (cfg_we) begin
            case (wps_reg_t'(cfg_addr))
                REG_MEAN_HEIGHT: mean_height_reg <= $signed(cfg_wdata);
                REG_HEAVE_AMP:   heave_amp_reg   <= cfg_wdata[21:0];
                REG_ROLL_AMP:    roll_amp_reg    <= cfg_wdata[17:0];
                REG_PITCH_AMP:   pitch_amp_reg   <= cfg_wdata[17:0];
                REG_FREQ_ONE:    freq_one_reg    <= cfg_wdata[23:0];
                REG_FREQ_TWO:    freq_two_reg    <= cfg_wdata[23:0];
                REG_WAVENUM_X:   wavenum_x_reg   <= $signed(cfg_wdata[23:0]);
                REG_WAVENUM_Y:   wavenum_y_reg   <= $signed(cfg_wdata[23:0]);
                default: begin
                end
            endcase
        end
    end

    // Phase coefficients in turns per unit, kept modulo 2^64.
    always_ff @(posedge aclk) begin
        coef_reg[0] <= 64'($signed({1'b0, freq_one_reg}) * INV_2PI);
        coef_reg[1] <= 64'(64'(wavenum_x_reg) * INV_2PI);
        coef_reg[2] <= 64'(64'(wavenum_y_reg) * INV_2PI_035);
        coef_reg[3] <= 64'($signed({1'b0, freq_two_reg}) * INV_2PI);
        coef_reg[4] <= 64'(-(64'(wavenum_x_reg) * INV_2PI_055));
        coef_reg[5] <= 64'(64'(wavenum_y_reg) * INV_2PI);
    end

    always_comb begin
        opnd[0] = {16'd0, s_data.sim_time};
        opnd[1] = 64'(s_data.pos_x);
        opnd[2] = 64'(s_data.pos_y);
        opnd[3] = {16'd0, s_data.sim_time};
        opnd[4] = 64'(s_data.pos_x);
        opnd[5] = 64'(s_data.pos_y);
    end

    always_ff @(posedge aclk) begin
        for (int k = 0; k < 6; k++) begin
            lo_reg[k]    <= 64'(coef_reg[k][31:0]) * 64'(opnd[k][31:0]);
            cross_reg[k] <= coef_reg[k][63:32] * opnd[k][31:0]
                          + coef_reg[k][31:0] * opnd[k][63:32];
            term_reg[k]  <= lo_reg[k] + {cross_reg[k], 32'd0};
        end
        ua_reg <= 32'((term_reg[0] + term_reg[1] + term_reg[2]) >> 32);
        ub_reg <= 32'((term_reg[3] + term_reg[4] + term_reg[5] + {OFF_1P2, 32'd0}) >> 32);
        hy_dly_reg[0] <= {s_data.heading[15], s_data.heading, 15'd0};
        for (int k = 1; k < HY_DLY; k++) begin
            hy_dly_reg[k] <= hy_dly_reg[k - 1];
        end
    end

    wps_sine u_sin_a0 (.aclk(aclk), .u(ua_reg),                .s(sin_a[0]));
    wps_sine u_sin_a1 (.aclk(aclk), .u(ub_reg),                .s(sin_a[1]));
    wps_sine u_sin_a2 (.aclk(aclk), .u(ua_reg + OFF_0P8),      .s(sin_a[2]));
    wps_sine u_sin_a3 (.aclk(aclk), .u(ua_reg + QUARTER_TURN), .s(sin_a[3]));
    wps_sine u_sin_a4 (.aclk(aclk), .u(ub_reg - OFF_0P4),      .s(sin_a[4]));

    assign hgt_sum = 33'(mean_height_reg) + 33'(heave_reg);
    assign hr_prod = 64'(rad_r_reg) * INV_4PI;
    assign hp_prod = 64'(rad_p_reg) * INV_4PI;

    always_ff @(posedge aclk) begin
        mix_reg[0] <= mul30(WT_070, sin_a[0]);
        mix_reg[1] <= mul30(WT_030, sin_a[1]);
        mix_reg[2] <= mul30(WT_065, sin_a[1]);
        mix_reg[3] <= mul30(WT_035, sin_a[2]);
        mix_reg[4] <= mul30(WT_070, sin_a[3]);
        mix_reg[5] <= mul30(WT_030, sin_a[4]);
        mh_reg <= 33'(mix_reg[0]) + 33'(mix_reg[1]);
        mr_reg <= 33'(mix_reg[2]) + 33'(mix_reg[3]);
        mp_reg <= 33'(mix_reg[4]) + 33'(mix_reg[5]);
        heave_reg <= 32'(round_shift(64'($signed({1'b0, heave_amp_reg})) * 64'(mh_reg), 30));
        rad_r_reg <= 36'(round_shift(64'($signed({1'b0, roll_amp_reg})) * 64'(mr_reg), 14));
        rad_p_reg <= 36'(round_shift(64'($signed({1'b0, pitch_amp_reg})) * 64'(mp_reg), 14));
        if (hgt_sum > 33'sd2147483647) begin
            hgt_reg <= 32'sh7FFF_FFFF;
        end else if (hgt_sum < -33'sd2147483648) begin
            hgt_reg <= 32'sh8000_0000;
        end else begin
            hgt_reg <= 32'(hgt_sum);
        end
        hr_reg <= hr_prod[63:32];
        hp_reg <= hp_prod[63:32];
        hgt_dly_reg[0] <= hgt_reg;
        for (int k = 1; k < HGT_DLY; k++) begin
            hgt_dly_reg[k] <= hgt_dly_reg[k - 1];
        end
    end

    wps_sine u_sin_r (.aclk(aclk), .u(hr_reg),                            .s(sr));
    wps_sine u_cos_r (.aclk(aclk), .u(hr_reg + QUARTER_TURN),             .s(cr));
    wps_sine u_sin_p (.aclk(aclk), .u(hp_reg),                            .s(sp));
    wps_sine u_cos_p (.aclk(aclk), .u(hp_reg + QUARTER_TURN),             .s(cp));
    wps_sine u_sin_y (.aclk(aclk), .u(hy_dly_reg[HY_DLY-1]),              .s(sy));
    wps_sine u_cos_y (.aclk(aclk), .u(hy_dly_reg[HY_DLY-1] + QUARTER_TURN), .s(cy));

    always_ff @(posedge aclk) begin
        cc_reg <= mul30(cr, cp);
        ss_reg <= mul30(sr, sp);
        sc_reg <= mul30(sr, cp);
        cs_reg <= mul30(cr, sp);
        cy_reg <= cy;
        sy_reg <= sy;
        tw1_reg <= mul30(cc_reg, cy_reg);
        tw2_reg <= mul30(ss_reg, sy_reg);
        tx1_reg <= mul30(sc_reg, cy_reg);
        tx2_reg <= mul30(cs_reg, sy_reg);
        ty1_reg <= mul30(cs_reg, cy_reg);
        ty2_reg <= mul30(sc_reg, sy_reg);
        tz1_reg <= mul30(cc_reg, sy_reg);
        tz2_reg <= mul30(ss_reg, cy_reg);
        w_reg  <= 33'(tw1_reg) + 33'(tw2_reg);
        qx_reg <= 33'(tx1_reg) - 33'(tx2_reg);
        qy_reg <= 33'(ty1_reg) + 33'(ty2_reg);
        qz_reg <= 33'(tz1_reg) - 33'(tz2_reg);
        out_reg.height <= hgt_dly_reg[HGT_DLY-1];
        out_reg.quat_w <= to_q15(w_reg);
        out_reg.quat_x <= to_q15(qx_reg);
        out_reg.quat_y <= to_q15(qy_reg);
        out_reg.quat_z <= to_q15(qz_reg);
    end

    assign s_ready  = (cnt_reg < CNT_W'(FIFO_DEPTH)) && !cfg_hold_reg;
    assign in_take  = s_valid && s_ready && !s_data.paused;
    assign q_pop    = (wr_ptr_reg != rd_ptr_reg) && (!m_valid_reg || m_ready);
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;
    assign out_take = m_valid_reg && m_ready;

    always_comb begin
        cnt_next = cnt_reg;
        if (in_take && !out_take) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (!in_take && out_take) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg      <= '0;
            wr_ptr_reg   <= '0;
            rd_ptr_reg   <= '0;
            cnt_reg      <= '0;
            cfg_hold_reg <= 1'b1;
            m_valid_reg  <= 1'b0;
        end else begin
            vld_reg      <= {vld_reg[PIPE_LAT-2:0], in_take};
            cnt_reg      <= cnt_next;
            cfg_hold_reg <= cfg_we;
            if (vld_reg[PIPE_LAT-1]) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (q_pop) begin
                rd_ptr_reg  <= rd_ptr_reg + 1'b1;
                m_valid_reg <= 1'b1;
            end else if (out_take) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (vld_reg[PIPE_LAT-1]) begin
            fifo_mem[wr_ptr_reg[IDX_W-1:0]] <= out_reg;
        end
        if (q_pop) begin
            m_data_reg <= fifo_mem[rd_ptr_reg[IDX_W-1:0]];
        end
    end

endmodule
